FILE: rtl/tbrb_pkg.sv
package tbrb_pkg;

    localparam int MODE_W    = 3;
    localparam int DATA_W    = 8;
    localparam int OFF_W     = 12;
    localparam int LEN_W     = 13;
    localparam int AMT_W     = 13;
    localparam int DEPTH_DEF = 4096;

    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PLACE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] data_in;
        logic [OFF_W-1:0]  offset;
        logic [LEN_W-1:0]  length;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic              done_res;
        logic [AMT_W-1:0]  amount;
        logic [AMT_W-1:0]  fill;
    } t_out;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_cmd;

endpackage

FILE: rtl/tbrb_ctrl.sv
module tbrb_ctrl
    import tbrb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_slot_free;

    // output register can take a word when empty or being drained this cycle
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (w_slot_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec    = (r_state == S_EXEC);
        o_cmd.load    = (r_state == S_LOAD) && w_slot_free;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/tbrb_dp.sv
module tbrb_dp
    import tbrb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_in  i_in_item,
    output t_out o_out_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = ((CW > AMT_W) ? CW : AMT_W) + 1;
    localparam logic [WW-1:0] DEPTH_X = WW'(DEPTH);
    localparam logic [PW:0]   DEPTH_S = (PW + 1)'(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];

    t_in               r_item;
    t_out              r_out;
    logic [PW-1:0]     r_wp;
    logic [PW-1:0]     r_rp;
    logic [CW-1:0]     r_held;
    logic [DATA_W-1:0] r_rd;
    logic              r_done;
    logic              r_rsel;
    logic [AMT_W-1:0]  r_amt;

    logic [PW-1:0]     n_wp;
    logic [PW-1:0]     n_rp;
    logic [CW-1:0]     n_held;
    logic              n_done;
    logic              n_rsel;
    logic [AMT_W-1:0]  n_amt;

    logic              w_we;
    logic              w_re;
    logic [PW-1:0]     w_waddr;
    logic [PW-1:0]     w_raddr;

    logic [WW-1:0]     w_held;
    logic [WW-1:0]     w_off;
    logic [WW-1:0]     w_len;
    logic [WW-1:0]     w_n;
    logic [WW-1:0]     w_free;
    logic [PW:0]       w_rp_off;
    logic [PW:0]       w_wp_off;
    logic [PW:0]       w_wp_off1;
    logic [PW:0]       w_rp_n;
    logic [PW:0]       w_wp1;
    logic [PW:0]       w_rp1;

    // sums stay below twice the depth on every path that uses them
    function automatic logic [PW-1:0] wrap(input logic [PW:0] s);
        logic [PW:0] t;
        t = s - DEPTH_S;
        if (s >= DEPTH_S) begin
            wrap = t[PW-1:0];
        end else begin
            wrap = s[PW-1:0];
        end
    endfunction

    assign w_held    = WW'(r_held);
    assign w_off     = WW'(r_item.offset);
    assign w_len     = WW'(r_item.length);
    assign w_n       = (w_len < w_held) ? w_len : w_held;
    assign w_free    = DEPTH_X - w_held;
    assign w_rp_off  = {1'b0, r_rp} + w_off[PW:0];
    assign w_wp_off  = {1'b0, r_wp} + w_off[PW:0];
    assign w_wp_off1 = w_wp_off + (PW + 1)'(1);
    assign w_rp_n    = {1'b0, r_rp} + w_n[PW:0];
    assign w_wp1     = {1'b0, r_wp} + (PW + 1)'(1);
    assign w_rp1     = {1'b0, r_rp} + (PW + 1)'(1);

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_held  = r_held;
        n_done  = 1'b0;
        n_rsel  = 1'b0;
        n_amt   = '0;
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_waddr = r_wp;
        w_raddr = r_rp;
        unique case (r_item.mode)
            MODE_APPEND: begin
                if (w_held != DEPTH_X) begin
                    w_we   = 1'b1;
                    n_wp   = wrap(w_wp1);
                    n_held = r_held + CW'(1);
                    n_done = 1'b1;
                end
            end
            MODE_PEEK: begin
                if (w_off < w_held) begin
                    w_re    = 1'b1;
                    w_raddr = wrap(w_rp_off);
                    n_rsel  = 1'b1;
                    n_done  = 1'b1;
                end
            end
            MODE_REMOVE: begin
                n_rp   = wrap(w_rp_n);
                n_held = r_held - w_n[CW-1:0];
                n_amt  = w_n[AMT_W-1:0];
                n_done = 1'b1;
            end
            MODE_PLACE: begin
                if (w_off < w_free) begin
                    w_we    = 1'b1;
                    w_waddr = wrap(w_wp_off);
                    n_wp    = wrap(w_wp_off1);
                    n_held  = r_held + CW'(1);
                    n_done  = 1'b1;
                end
            end
            MODE_POP: begin
                if (w_held != '0) begin
                    w_re   = 1'b1;
                    n_rp   = wrap(w_rp1);
                    n_held = r_held - CW'(1);
                    n_rsel = 1'b1;
                    n_done = 1'b1;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // byte store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_we) begin
            r_mem[w_waddr] <= r_item.data_in;
        end
        if (i_cmd.exec && w_re) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_held <= '0;
        end else if (i_cmd.exec) begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
        if (i_cmd.exec) begin
            r_done <= n_done;
            r_rsel <= n_rsel;
            r_amt  <= n_amt;
        end
        if (i_cmd.load) begin
            r_out.data_out <= r_rsel ? r_rd : '0;
            r_out.done_res <= r_done;
            r_out.amount   <= r_amt;
            r_out.fill     <= w_held[AMT_W-1:0];
        end
    end

    assign o_out_item = r_out;

endmodule

FILE: rtl/tcp_byte_ring_buffer.sv
// byte ring for a tcp send or receive stream, one operation per input word
// input channel: i_in_valid / o_in_ready carry i_in_item (mode, data_in,
// offset, length); modes are append, peek at offset, remove length,
// place at offset and pop
// output channel: o_out_valid / i_out_ready carry o_out_item (data_out,
// done_res, amount, fill), exactly one result word per input word
// the input word is registered, then the pointers are updated with the
// store access, then the registered read data is loaded into the
// output register once that register can take it
// a word is taken only once the last one has left the exec and load
// states; the next word is taken while the last result still waits
// in the output register
// a stalled receiver holds the result in the output register; a further
// word completes its work but waits for the register before finishing,
// and the input stays not ready meanwhile
// reset empties the ring: both pointers and the held count go to zero, no
// clearing pass; the byte store itself is not cleared
module tcp_byte_ring_buffer
    import tbrb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_item,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_item
);

    t_cmd w_cmd;

    tbrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    tbrb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready ##1 !o_in_ready)
        else $error("input taken again before the word finished");

    a_refused_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.done_res) |->
        (o_out_item.amount == '0 && o_out_item.data_out == '0))
        else $error("refused operation reports data or amount");
`endif

endmodule

FILE: tb/tb_tcp_byte_ring_buffer.sv
module tb_tcp_byte_ring_buffer;
    import tbrb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = DEPTH_DEF;
    localparam int RAND_WORDS = 1850;
    localparam logic [MODE_W-1:0] MODE_FIRST_UNUSED = MODE_POP + 3'd1;

    typedef struct packed {
        t_in  word;
        t_out result;
    } t_ring_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in  in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_item;

    // ring as the block should see it
    logic [DATA_W-1:0] ring_mem [RING_DEPTH];
    bit                ring_written [RING_DEPTH];
    int                wr_ptr = 0;
    int                rd_ptr = 0;
    int                held = 0;

    t_ring_cmd cmd_q [$];
    t_out      ring_result_q [$];
    t_ring_cmd cur_cmd;
    t_out      in_flight_result;
    t_out      want;
    bit        failed = 1'b0;

    int burst_left = 0;
    int gap_left = 0;
    int rx_style = 0;
    int rx_span = 0;
    int rx_hold = 0;
    bit rx_level = 1'b0;

    tcp_byte_ring_buffer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out ring_apply(input t_in w);
        t_out r;
        int   n;
        int   a;
        r = '0;
        case (w.mode)
            MODE_APPEND: begin
                if (held < RING_DEPTH) begin
                    ring_mem[wr_ptr] = w.data_in;
                    ring_written[wr_ptr] = 1'b1;
                    wr_ptr = (wr_ptr + 1) % RING_DEPTH;
                    held++;
                    r.done_res = 1'b1;
                end
            end
            MODE_PEEK: begin
                if (int'(w.offset) < held) begin
                    r.data_out = ring_mem[(rd_ptr + int'(w.offset)) % RING_DEPTH];
                    r.done_res = 1'b1;
                end
            end
            MODE_REMOVE: begin
                n = (int'(w.length) < held) ? int'(w.length) : held;
                rd_ptr = (rd_ptr + n) % RING_DEPTH;
                held -= n;
                r.amount = AMT_W'(n);
                r.done_res = 1'b1;
            end
            MODE_PLACE: begin
                if (int'(w.offset) < RING_DEPTH - held) begin
                    a = (wr_ptr + int'(w.offset)) % RING_DEPTH;
                    ring_mem[a] = w.data_in;
                    ring_written[a] = 1'b1;
                    wr_ptr = (wr_ptr + int'(w.offset) + 1) % RING_DEPTH;
                    held++;
                    r.done_res = 1'b1;
                end
            end
            MODE_POP: begin
                if (held > 0) begin
                    r.data_out = ring_mem[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                    held--;
                    r.done_res = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.fill = AMT_W'(held);
        return r;
    endfunction

    function automatic t_in word_of(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] d,
                                    input logic [OFF_W-1:0] o, input logic [LEN_W-1:0] l);
        t_in w;
        w.mode = m;
        w.data_in = d;
        w.offset = o;
        w.length = l;
        return w;
    endfunction

    function automatic void push_word(input t_in w);
        t_ring_cmd c;
        c.word = w;
        c.result = ring_apply(w);
        cmd_q.push_back(c);
    endfunction

    // a read of a slot skipped over by a place is never issued: a remove of one byte is sent instead
    function automatic t_in keep_reads_defined(input t_in w);
        t_in v;
        v = w;
        if ((v.mode == MODE_PEEK && int'(v.offset) < held &&
             !ring_written[(rd_ptr + int'(v.offset)) % RING_DEPTH]) ||
            (v.mode == MODE_POP && held > 0 && !ring_written[rd_ptr])) begin
            v.mode = MODE_REMOVE;
            v.length = LEN_W'(1);
        end
        return v;
    endfunction

    // profile 0 balanced, 1 filling, 2 draining
    function automatic t_in plan_word(input int profile);
        t_in w;
        int  r;
        int  sel;
        int  room;
        w = $bits(t_in)'({$urandom, $urandom});
        r = $urandom_range(0, 99);
        room = RING_DEPTH - held;
        case (profile)
            1: sel = (r < 55) ? 0 : (r < 70) ? 1 : (r < 85) ? 2 : (r < 88) ? 3 : (r < 98) ? 4 : 5;
            2: sel = (r < 15) ? 0 : (r < 20) ? 1 : (r < 40) ? 2 : (r < 55) ? 3 : (r < 97) ? 4 : 5;
            default: sel = (r < 30) ? 0 : (r < 40) ? 1 : (r < 60) ? 2 : (r < 70) ? 3 :
                           (r < 95) ? 4 : 5;
        endcase
        r = $urandom_range(0, 99);
        case (sel)
            0: begin
                w.mode = MODE_APPEND;
            end
            1: begin
                w.mode = MODE_PLACE;
                if (room > 0 && r < 70) begin
                    w.offset = OFF_W'($urandom_range(0, (room > 4) ? 3 : room - 1));
                end else if (room > 0 && r < 85) begin
                    w.offset = OFF_W'($urandom_range(0, (room > 4096) ? 4095 : room - 1));
                end
            end
            2: begin
                w.mode = MODE_PEEK;
                if (held > 0 && r < 80) begin
                    w.offset = OFF_W'($urandom_range(0, held - 1));
                end
            end
            3: begin
                w.mode = MODE_REMOVE;
                if (r < 60) begin
                    w.length = LEN_W'($urandom_range(0, 4));
                end else if (r < 85) begin
                    w.length = LEN_W'($urandom_range(0, held));
                end
            end
            4: begin
                w.mode = MODE_POP;
            end
            default: begin
                w.mode = MODE_FIRST_UNUSED + MODE_W'($urandom_range(0, 2));
            end
        endcase
        return keep_reads_defined(w);
    endfunction

    // sender: bursts of words separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                ring_result_q.push_back(in_flight_result);
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    cur_cmd = cmd_q.pop_front();
                    in_item <= cur_cmd.word;
                    in_flight_result = cur_cmd.result;
                    in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall style changes after each random span
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (rx_span == 0) begin
                rx_style = $urandom_range(0, 3);
                rx_span = $urandom_range(50, 300);
            end else begin
                rx_span--;
            end
            case (rx_style)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                2: out_ready <= ($urandom_range(0, 7) != 0);
                default: begin
                    if (rx_hold == 0) begin
                        rx_level = !rx_level;
                        rx_hold = rx_level ? $urandom_range(1, 6) : $urandom_range(1, 20);
                    end else begin
                        rx_hold--;
                    end
                    out_ready <= rx_level;
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (ring_result_q.size() == 0) begin
                $error("result word with nothing expected: %p", out_item);
                failed = 1'b1;
            end else begin
                want = ring_result_q.pop_front();
                if (out_item.data_out !== want.data_out) begin
                    $error("data_out: expected %0d, got %0d", want.data_out, out_item.data_out);
                    failed = 1'b1;
                end
                if (out_item.done_res !== want.done_res) begin
                    $error("done_res: expected %0d, got %0d", want.done_res, out_item.done_res);
                    failed = 1'b1;
                end
                if (out_item.amount !== want.amount) begin
                    $error("amount: expected %0d, got %0d", want.amount, out_item.amount);
                    failed = 1'b1;
                end
                if (out_item.fill !== want.fill) begin
                    $error("fill: expected %0d, got %0d", want.fill, out_item.fill);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        int  rand_words;
        int  profile;
        int  seg_left;
        t_in w;
        rand_words = 0;
        profile = 0;
        seg_left = 0;

        // empty ring pop, peek and remove, unused modes, then a short fill with a far place and a drain
        push_word(word_of(MODE_POP, 8'h11, '0, '0));
        push_word(word_of(MODE_PEEK, 8'h22, '0, '0));
        push_word(word_of(MODE_REMOVE, 8'h33, '0, '0));
        push_word(word_of(MODE_FIRST_UNUSED, '1, '1, '1));
        push_word(word_of(MODE_FIRST_UNUSED + 3'd1, 8'h5A, 12'hA5A, 13'h0A5A));
        push_word(word_of(MODE_FIRST_UNUSED + 3'd2, '0, '0, '0));
        push_word(word_of(MODE_APPEND, 8'h00, '0, '0));
        push_word(word_of(MODE_APPEND, 8'hFF, '1, '1));
        push_word(word_of(MODE_APPEND, 8'hA5, '0, '0));
        push_word(word_of(MODE_PEEK, '0, 12'd0, '0));
        push_word(word_of(MODE_PEEK, '0, 12'd2, '0));
        push_word(word_of(MODE_PEEK, '0, 12'd3, '0));
        push_word(word_of(MODE_PEEK, '0, 12'd4095, '0));
        push_word(word_of(MODE_PLACE, 8'h5A, 12'd0, '0));
        push_word(word_of(MODE_PLACE, 8'h3C, 12'd4095, '0));
        push_word(word_of(MODE_PLACE, 8'hC3, 12'd4091, '0));
        push_word(word_of(MODE_POP, '0, '0, '0));
        push_word(word_of(MODE_REMOVE, '0, '0, 13'd2));
        push_word(word_of(MODE_POP, '0, '0, '0));
        push_word(word_of(MODE_REMOVE, '0, '0, 13'd8191));
        push_word(word_of(MODE_REMOVE, '0, '0, 13'd4096));

        while (rand_words < RAND_WORDS) begin
            if (seg_left == 0) begin
                profile = $urandom_range(0, 2);
                seg_left = $urandom_range(20, 80);
            end
            seg_left--;
            w = plan_word(profile);
            push_word(w);
            if (w.mode <= MODE_POP) begin
                rand_words++;
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() != 0 || in_valid) begin
            @(posedge i_clk);
        end
        while (ring_result_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
